>>> sv/fcull_pkg.sv
// Shared types and constants for the frustum box culling block.
// Depends on nothing; imported by fcull_plane and frustum_box_cull.
package fcull_pkg;

    // Six planes in mask bit order: right, left, bottom, top, front, back.
    localparam int NUM_PLANES  = 6;
    localparam int FIELD_BITS  = 16;
    // D is Q12.4 and the products are Q.18, so D is aligned by 14 bits.
    localparam int D_SHIFT     = 14;
    localparam int D_ALIGNED   = FIELD_BITS + D_SHIFT;

    // Configuration port layout: 64-bit registers at byte address 8*i.
    localparam int ADDR_BITS   = 6;
    localparam int DATA_BITS   = 64;

    localparam logic [2:0] REG_PLANE_RIGHT  = 3'd0;
    localparam logic [2:0] REG_PLANE_LEFT   = 3'd1;
    localparam logic [2:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [2:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [2:0] REG_PLANE_FRONT  = 3'd4;
    localparam logic [2:0] REG_PLANE_BACK   = 3'd5;
    localparam logic [2:0] REG_FLIP_DEPTH   = 3'd6;

    // One plane as packed in its register: A in the low field, D in the top.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] d;
        logic signed [FIELD_BITS-1:0] c;
        logic signed [FIELD_BITS-1:0] b;
        logic signed [FIELD_BITS-1:0] a;
    } t_plane;

endpackage

>>> sv/fcull_plane.sv
// Four-stage evaluation of one frustum plane against a box.
// Depends on fcull_pkg; instantiated six times by frustum_box_cull.
module fcull_plane #(
    parameter int CW = 17
) (
    input  logic                  i_clk,
    input  fcull_pkg::t_plane     i_plane,
    input  logic signed [CW-1:0]  i_x0,
    input  logic signed [CW-1:0]  i_x1,
    input  logic signed [CW-1:0]  i_y0,
    input  logic signed [CW-1:0]  i_y1,
    input  logic signed [CW-1:0]  i_z0,
    input  logic signed [CW-1:0]  i_z1,
    output logic                  o_outside
);
    import fcull_pkg::*;

    localparam int PW = FIELD_BITS + CW;
    localparam int SW = ((PW > D_ALIGNED) ? PW : D_ALIGNED) + 2;

    logic signed [PW-1:0]         r_px0, r_px1, r_py0, r_py1, r_pz0, r_pz1;
    logic signed [FIELD_BITS-1:0] r_d1, r_d2;
    logic signed [PW-1:0]         r_mx, r_my, r_mz;
    logic signed [SW-1:0]         r_sxy, r_szd;
    logic signed [SW-1:0]         n_sum;
    logic signed [SW-1:0]         n_dal;
    logic                         r_out;

    // Stage one: the six products. The largest corner value of the plane is
    // the sum of the larger product on each axis, so eight corners need six.
    always_ff @(posedge i_clk) begin
        r_px0 <= PW'(i_plane.a) * PW'(i_x0);
        r_px1 <= PW'(i_plane.a) * PW'(i_x1);
        r_py0 <= PW'(i_plane.b) * PW'(i_y0);
        r_py1 <= PW'(i_plane.b) * PW'(i_y1);
        r_pz0 <= PW'(i_plane.c) * PW'(i_z0);
        r_pz1 <= PW'(i_plane.c) * PW'(i_z1);
        r_d1  <= i_plane.d;
    end

    // Stage two: pick the larger product on each axis.
    always_ff @(posedge i_clk) begin
        r_mx <= (r_px0 > r_px1) ? r_px0 : r_px1;
        r_my <= (r_py0 > r_py1) ? r_py0 : r_py1;
        r_mz <= (r_pz0 > r_pz1) ? r_pz0 : r_pz1;
        r_d2 <= r_d1;
    end

    // D scaled into the product format.
    assign n_dal = {{(SW-D_ALIGNED){r_d2[FIELD_BITS-1]}}, r_d2, {D_SHIFT{1'b0}}};

    // Stage three: two partial sums.
    always_ff @(posedge i_clk) begin
        r_sxy <= SW'(r_mx) + SW'(r_my);
        r_szd <= SW'(r_mz) + n_dal;
    end

    // Stage four: the plane rejects the box when even the best corner is <= 0.
    assign n_sum = r_sxy + r_szd;

    always_ff @(posedge i_clk) begin
        r_out <= n_sum[SW-1] || (n_sum == '0);
    end

    assign o_outside = r_out;

endmodule

>>> sv/frustum_box_cull.sv
// Top level of the frustum box culling block: configuration registers,
// input capture and the six plane pipelines. Depends on fcull_pkg, fcull_plane.
//
// Tests one axis-aligned box per clock cycle against six planes. A box is
// taken whenever start is high; busy never rises. Its result appears on
// o_visible and o_outside_mask with o_valid high for one cycle, in the same
// order as the boxes. Between start and the result lie the registers of
// coordinate capture, products, per-axis maximum, partial sums and the final
// sign test. Results cannot be held off, so the receiver must take each one
// in the cycle it is shown.
// Plane and depth-flip registers may be written only while no box is in flight.
module frustum_box_cull #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Box beat
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_min_x,
    input  logic signed [COORD_BITS-1:0]        i_min_y,
    input  logic signed [COORD_BITS-1:0]        i_min_z,
    input  logic signed [COORD_BITS-1:0]        i_max_x,
    input  logic signed [COORD_BITS-1:0]        i_max_y,
    input  logic signed [COORD_BITS-1:0]        i_max_z,
    // Result beat
    output logic                                o_valid,
    output logic                                o_visible,
    output logic [fcull_pkg::NUM_PLANES-1:0]    o_outside_mask,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcull_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [fcull_pkg::DATA_BITS-1:0]     pwdata,
    output logic [fcull_pkg::DATA_BITS-1:0]     prdata,
    output logic                                pready
);
    import fcull_pkg::*;

    // Coordinates are one bit wider so that negating z is exact.
    localparam int CW      = COORD_BITS + 1;
    localparam int LATENCY = 5;

    t_plane                r_plane [NUM_PLANES];
    logic                  r_flip;
    logic [2:0]            n_idx;
    logic                  n_wr;

    logic signed [CW-1:0]  r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic signed [CW-1:0]  n_z0, n_z1;
    logic [LATENCY-1:0]    r_vld;
    logic [NUM_PLANES-1:0] n_mask;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign n_idx  = paddr[ADDR_BITS-1:3];
    assign n_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_plane[i] <= '0;
            end
            r_flip <= 1'b0;
        end else if (n_wr) begin
            case (n_idx)
                REG_PLANE_RIGHT:  r_plane[0] <= pwdata;
                REG_PLANE_LEFT:   r_plane[1] <= pwdata;
                REG_PLANE_BOTTOM: r_plane[2] <= pwdata;
                REG_PLANE_TOP:    r_plane[3] <= pwdata;
                REG_PLANE_FRONT:  r_plane[4] <= pwdata;
                REG_PLANE_BACK:   r_plane[5] <= pwdata;
                REG_FLIP_DEPTH:   r_flip     <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (n_idx)
            REG_PLANE_RIGHT:  prdata = r_plane[0];
            REG_PLANE_LEFT:   prdata = r_plane[1];
            REG_PLANE_BOTTOM: prdata = r_plane[2];
            REG_PLANE_TOP:    prdata = r_plane[3];
            REG_PLANE_FRONT:  prdata = r_plane[4];
            REG_PLANE_BACK:   prdata = r_plane[5];
            REG_FLIP_DEPTH:   prdata = {{(DATA_BITS-1){1'b0}}, r_flip};
            default:          prdata = '0;
        endcase
    end

    // The block never refuses a box.
    assign busy = 1'b0;

    // Depth flip applied on the way in.
    assign n_z0 = r_flip ? -CW'(i_min_z) : CW'(i_min_z);
    assign n_z1 = r_flip ? -CW'(i_max_z) : CW'(i_max_z);

    // Capture stage for the box corners.
    always_ff @(posedge i_clk) begin
        r_x0 <= CW'(i_min_x);
        r_x1 <= CW'(i_max_x);
        r_y0 <= CW'(i_min_y);
        r_y1 <= CW'(i_max_y);
        r_z0 <= n_z0;
        r_z1 <= n_z1;
    end

    // Valid bits travel alongside the plane pipelines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start && !busy};
        end
    end

    // One evaluation pipeline per plane.
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fcull_plane #(
            .CW (CW)
        ) u_plane (
            .i_clk     (i_clk),
            .i_plane   (r_plane[p]),
            .i_x0      (r_x0),
            .i_x1      (r_x1),
            .i_y0      (r_y0),
            .i_y1      (r_y1),
            .i_z0      (r_z0),
            .i_z1      (r_z1),
            .o_outside (n_mask[p])
        );
    end

    // Result beat.
    assign o_valid        = r_vld[LATENCY-1];
    assign o_outside_mask = n_mask;
    assign o_visible      = (n_mask == '0);

endmodule

>>> sv/fcull_chk.sv
// Port-level checker for frustum_box_cull, attached by the bind below.
// Depends on fcull_pkg for the mask width.
module fcull_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic                             o_visible,
    input logic [fcull_pkg::NUM_PLANES-1:0] o_outside_mask
);
    import fcull_pkg::*;

    // The block takes a box in every cycle.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // Every accepted box yields a result on o_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("result missing for accepted box");

    // No result appears without a matching box taken earlier.
    a_no_spurious: assert property (@(posedge i_clk)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) &&
         $past(i_rst_n, 4) && $past(i_rst_n, 5) && !$past(start, 5))
        |-> !o_valid)
        else $error("result without an accepted box");

    // Visibility agrees with the rejection mask.
    a_visible_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_visible == (o_outside_mask == '0)))
        else $error("visible disagrees with outside mask");

endmodule

bind frustum_box_cull fcull_chk u_fcull_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_visible      (o_visible),
    .o_outside_mask (o_outside_mask)
);

>>> bench/cull_checker.sv
// Result checker for the frustum box culling block: keeps its own copy of the
// planes and depth flip, predicts the mask of every box taken and compares.
// Depends on fcull_pkg; instantiated by the testbench top beside the block.
module cull_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Box beat as seen on the block's ports
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic signed [COORD_BITS-1:0]        i_min_x,
    input  logic signed [COORD_BITS-1:0]        i_min_y,
    input  logic signed [COORD_BITS-1:0]        i_min_z,
    input  logic signed [COORD_BITS-1:0]        i_max_x,
    input  logic signed [COORD_BITS-1:0]        i_max_y,
    input  logic signed [COORD_BITS-1:0]        i_max_z,
    // Result beat
    input  logic                                i_valid,
    input  logic                                i_visible,
    input  logic [fcull_pkg::NUM_PLANES-1:0]    i_outside_mask,
    // Configuration writes
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [fcull_pkg::ADDR_BITS-1:0]     i_paddr,
    input  logic [fcull_pkg::DATA_BITS-1:0]     i_pwdata,
    // Status for the top
    output int                                  o_mismatches,
    output int                                  o_boxes_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcull_pkg::*;

    typedef struct packed {
        logic                   visible;
        logic [NUM_PLANES-1:0]  mask;
    } t_cull_verdict;

    t_plane             planes [NUM_PLANES];
    logic               depth_flip;
    t_cull_verdict      pending_verdicts [$];
    t_cull_verdict      oldest;
    logic [NUM_PLANES-1:0] predicted_mask;
    int                 results_seen = 0;

    // Set of planes that have every corner of the box on or behind them.
    function automatic logic [NUM_PLANES-1:0] rejecting_planes(
        input logic signed [COORD_BITS-1:0] lo_x, lo_y, lo_z,
        input logic signed [COORD_BITS-1:0] hi_x, hi_y, hi_z
    );
        longint xs [2];
        longint ys [2];
        longint zs [2];
        longint a, b, c, d, s;
        logic all_behind;
        logic [NUM_PLANES-1:0] mask;
        xs[0] = lo_x;
        xs[1] = hi_x;
        ys[0] = lo_y;
        ys[1] = hi_y;
        zs[0] = lo_z;
        zs[1] = hi_z;
        // Negation is done at full width, so the most negative z stays exact.
        if (depth_flip) begin
            zs[0] = -zs[0];
            zs[1] = -zs[1];
        end
        mask = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            a = $signed(planes[p].a);
            b = $signed(planes[p].b);
            c = $signed(planes[p].c);
            // D is Q12.4; scaling brings it to the Q.18 of the products.
            d = longint'($signed(planes[p].d)) * (longint'(1) << D_SHIFT);
            all_behind = 1'b1;
            for (int k = 0; k < 8; k++) begin
                s = a * xs[k % 2] + b * ys[(k / 2) % 2] + c * zs[k / 4] + d;
                if (s > 0) begin
                    all_behind = 1'b0;
                end
            end
            mask[p] = all_behind;
        end
        return mask;
    endfunction

    // One line per mismatch, and each one counted.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s, got %0h, expected %0h",
                 results_seen, what, got, want);
        o_mismatches = o_mismatches + 1;
    endtask

    // Shadow copy of the registers, written on the access phase of a write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                planes[p] <= '0;
            end
            depth_flip <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && i_pready) begin
            if (i_paddr[ADDR_BITS-1:3] <= REG_PLANE_BACK) begin
                planes[i_paddr[ADDR_BITS-1:3]] <= i_pwdata;
            end else if (i_paddr[ADDR_BITS-1:3] == REG_FLIP_DEPTH) begin
                depth_flip <= i_pwdata[0];
            end
        end
    end

    // Compare each result beat with the oldest prediction, then record new boxes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid === 1'b1) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with no box in flight",
                                    {i_visible, i_outside_mask}, 0);
                end else begin
                    oldest = pending_verdicts.pop_front();
                    if (i_visible !== oldest.visible) begin
                        report_mismatch("visible", i_visible, oldest.visible);
                    end
                    if (i_outside_mask !== oldest.mask) begin
                        report_mismatch("outside_mask", i_outside_mask, oldest.mask);
                    end
                end
                results_seen = results_seen + 1;
            end
            if (i_start && !i_busy) begin
                predicted_mask = rejecting_planes(i_min_x, i_min_y, i_min_z,
                                                  i_max_x, i_max_y, i_max_z);
                pending_verdicts.push_back('{visible: (predicted_mask == '0),
                                             mask: predicted_mask});
            end
        end
        o_boxes_in_flight <= pending_verdicts.size();
    end

endmodule

>>> bench/testbench.sv
// Testbench top for frustum_box_cull: clock, reset, register writes and box
// stimulus, with the verdict taken from cull_checker. Depends on fcull_pkg,
// cull_checker and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcull_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int ONE_Q14    = 16384;
    // Index past the last register; writes there must be ignored.
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int PHASE_BOXES = 90;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic signed [COORD_BITS-1:0]   i_min_x = '0;
    logic signed [COORD_BITS-1:0]   i_min_y = '0;
    logic signed [COORD_BITS-1:0]   i_min_z = '0;
    logic signed [COORD_BITS-1:0]   i_max_x = '0;
    logic signed [COORD_BITS-1:0]   i_max_y = '0;
    logic signed [COORD_BITS-1:0]   i_max_z = '0;
    logic                           o_valid;
    logic                           o_visible;
    logic [NUM_PLANES-1:0]          o_outside_mask;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ADDR_BITS-1:0]           paddr = '0;
    logic [DATA_BITS-1:0]           pwdata = '0;
    logic [DATA_BITS-1:0]           prdata;
    logic                           pready;

    int                             mismatches;
    int                             boxes_in_flight;
    logic [DATA_BITS-1:0]           frustum_regs [NUM_PLANES];

    always #10 i_clk = ~i_clk;

    frustum_box_cull #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_min_x        (i_min_x),
        .i_min_y        (i_min_y),
        .i_min_z        (i_min_z),
        .i_max_x        (i_max_x),
        .i_max_y        (i_max_y),
        .i_max_z        (i_max_z),
        .o_valid        (o_valid),
        .o_visible      (o_visible),
        .o_outside_mask (o_outside_mask),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    cull_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_min_x            (i_min_x),
        .i_min_y            (i_min_y),
        .i_min_z            (i_min_z),
        .i_max_x            (i_max_x),
        .i_max_y            (i_max_y),
        .i_max_z            (i_max_z),
        .i_valid            (o_valid),
        .i_visible          (o_visible),
        .i_outside_mask     (o_outside_mask),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_mismatches       (mismatches),
        .o_boxes_in_flight  (boxes_in_flight)
    );

    // Packs one plane as its register holds it: A low, D high.
    function automatic logic [DATA_BITS-1:0] plane_word(input int a, b, c, d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    // Setup phase, access phase held until pready, then the port released.
    task automatic write_reg(input logic [2:0] index, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_frustum(input logic flip);
        for (int p = 0; p < NUM_PLANES; p++) begin
            write_reg(3'(p), frustum_regs[p]);
        end
        write_reg(REG_FLIP_DEPTH, {{(DATA_BITS-1){1'b0}}, flip});
    endtask

    // Axis-aligned cube of the given half width (raw Q12.4) about the origin.
    task automatic set_cube(input int half);
        frustum_regs[REG_PLANE_RIGHT]  = plane_word(-ONE_Q14, 0, 0, half);
        frustum_regs[REG_PLANE_LEFT]   = plane_word(ONE_Q14, 0, 0, half);
        frustum_regs[REG_PLANE_BOTTOM] = plane_word(0, ONE_Q14, 0, half);
        frustum_regs[REG_PLANE_TOP]    = plane_word(0, -ONE_Q14, 0, half);
        frustum_regs[REG_PLANE_FRONT]  = plane_word(0, 0, ONE_Q14, half);
        frustum_regs[REG_PLANE_BACK]   = plane_word(0, 0, -ONE_Q14, half);
    endtask

    // Random normals; D mostly positive so that boxes near the origin pass often.
    task automatic set_random_planes();
        for (int p = 0; p < NUM_PLANES; p++) begin
            frustum_regs[p] = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) begin
                frustum_regs[p][63:48] = 16'($urandom_range(0, 4000));
            end
        end
    endtask

    // Every plane given the same packed pattern, for the field extremes.
    task automatic set_uniform_planes(input logic [15:0] field);
        for (int p = 0; p < NUM_PLANES; p++) begin
            frustum_regs[p] = {4{field}};
        end
    endtask

    // One box beat, optionally preceded by a short gap with start low.
    task automatic send_box(input logic [15:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
                            input bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_min_x <= lo_x;
        i_min_y <= lo_y;
        i_min_z <= lo_z;
        i_max_x <= hi_x;
        i_max_y <= hi_y;
        i_max_z <= hi_z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Half the boxes near the origin, the rest points, inverted boxes and raw noise.
    task automatic send_random_box(input bit gaps);
        int shape;
        int cen [3];
        int half [3];
        logic [15:0] lo [3];
        logic [15:0] hi [3];
        shape = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            cen[k]  = int'($urandom_range(0, 6000)) - 3000;
            half[k] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
            if (shape <= 4) begin
                lo[k] = 16'(cen[k] - half[k]);
                hi[k] = 16'(cen[k] + half[k]);
            end else if (shape <= 6) begin
                lo[k] = 16'($urandom);
                hi[k] = lo[k];
            end else if (shape == 7) begin
                lo[k] = 16'(cen[k] + half[k]);
                hi[k] = 16'(cen[k] - half[k]);
            end else begin
                lo[k] = 16'($urandom);
                hi[k] = 16'($urandom);
            end
        end
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], gaps);
    endtask

    // Stop sending and wait until every box taken has returned its result.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (boxes_in_flight != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_phase(input bit gaps);
        for (int n = 0; n < PHASE_BOXES; n++) begin
            send_random_box(gaps);
        end
        drain();
    endtask

    // Generous upper bound on the whole run.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int guard;
        guard = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset planes are all zero, so every box is rejected by all six.
        send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_box(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 0);
        drain();

        // Cube of half width 100.0: inside, beyond each face, touching, straddling.
        set_cube(1600);
        write_frustum(1'b0);
        send_box(-16'sd160, -16'sd160, -16'sd160, 16'sd160, 16'sd160, 16'sd160, 0);
        send_box(16'sd1700, 16'sd0, 16'sd0, 16'sd2000, 16'sd10, 16'sd10, 0);
        send_box(-16'sd2000, 16'sd0, 16'sd0, -16'sd1700, 16'sd10, 16'sd10, 0);
        send_box(16'sd0, -16'sd2000, 16'sd0, 16'sd10, -16'sd1600, 16'sd10, 0);
        send_box(16'sd0, 16'sd1600, 16'sd0, 16'sd10, 16'sd2000, 16'sd10, 0);
        send_box(16'sd0, 16'sd0, -16'sd2000, 16'sd10, 16'sd10, -16'sd1700, 0);
        send_box(16'sd0, 16'sd0, 16'sd1700, 16'sd10, 16'sd10, 16'sd2000, 0);
        // A point exactly on the right face gives zero there and is rejected.
        send_box(16'sd1600, 16'sd0, 16'sd0, 16'sd1600, 16'sd0, 16'sd0, 0);
        send_box(16'sd1500, 16'sd0, 16'sd0, 16'sd1700, 16'sd0, 16'sd0, 0);
        // Min above max is tested corner by corner as given.
        send_box(16'sd1700, 16'sd0, 16'sd0, 16'sd1500, 16'sd0, 16'sd0, 0);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        drain();

        // Depth flipped, including negation of the most negative z.
        write_reg(REG_FLIP_DEPTH, 64'd1);
        send_box(16'sd0, 16'sd0, 16'sd1700, 16'sd10, 16'sd10, 16'sd2000, 0);
        send_box(16'sd0, 16'sd0, 16'h8000, 16'sd0, 16'sd0, 16'h8000, 0);
        send_box(16'sd0, 16'sd0, 16'h7fff, 16'sd0, 16'sd0, 16'h7fff, 0);
        drain();

        // Plane fields at their positive and negative extremes.
        set_uniform_planes(16'h7fff);
        write_frustum(1'b0);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        drain();
        set_uniform_planes(16'h8000);
        write_frustum(1'b1);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_box(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        drain();

        // Random cube: half a phase of boxes, a full pause, then a whole phase.
        set_cube($urandom_range(800, 2400));
        write_frustum(1'b0);
        for (int n = 0; n < PHASE_BOXES / 2; n++) begin
            send_random_box(1);
        end
        drain();
        random_phase(1);

        set_random_planes();
        write_frustum(1'b1);
        random_phase(1);

        // A write past the last register must leave the set unchanged.
        set_random_planes();
        write_frustum(1'b0);
        write_reg(REG_SPARE, {$urandom, $urandom});
        random_phase(1);

        set_cube($urandom_range(800, 2400));
        write_frustum(1'b1);
        random_phase(1);

        // Final stretch back to back, with no gaps.
        set_random_planes();
        write_frustum(1'($urandom_range(0, 1)));
        for (int n = 0; n < PHASE_BOXES / 2; n++) begin
            send_random_box(0);
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (boxes_in_flight != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && boxes_in_flight == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
